/* design/mscac_pkg.sv */
// ============================================================================
// mscac_pkg
// Shared sizes, types and state codes for the minimum covering span block.
// ============================================================================
package mscac_pkg;

    localparam int MAX_COLORS = 64;
    localparam int WIN_DEPTH  = 1024;

    localparam int COLOR_W = 6;
    localparam int POS_W   = 31;
    localparam int CFG_W   = 7;

    localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int COL_IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int DIST_W    = $clog2(MAX_COLORS + 1);
    localparam int CMP_W     = (DIST_W > CFG_W) ? DIST_W : CFG_W;

    // largest colour count the register can ask for
    localparam int K_MAX_INT = (MAX_COLORS > 127) ? 127 : MAX_COLORS;

    localparam logic [CFG_W-1:0]  K_MAX      = CFG_W'(K_MAX_INT);
    localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(64);
    localparam logic [POS_W-1:0]  NO_SPAN    = {POS_W{1'b1}};
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WIN_DEPTH);
    localparam logic [WIN_AW-1:0] PTR_LAST   = WIN_AW'(WIN_DEPTH - 1);

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   position;
    } win_entry_t;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_FRONT_RD  = 7'b0000010,
        ST_FRONT_CNT = 7'b0000100,
        ST_FRONT_CHK = 7'b0001000,
        ST_PUSH      = 7'b0010000,
        ST_PUSH_CNT  = 7'b0100000,
        ST_DONE      = 7'b1000000
    } seq_state_t;

endpackage

/* design/min_span_covering_all_colors.sv */
// ============================================================================
// min_span_covering_all_colors
// Smallest window over sorted colour-tagged points that holds every colour.
// ============================================================================
// Input words (color, position) arrive on in_valid/in_ready in ascending
// position order. Each accepted word yields exactly one output word on
// out_valid/out_ready: best span so far (all ones when none), a flag for
// the current window holding every colour, and a sticky overflow flag.
// colors_in_use is written through cfg_valid/cfg_ready/cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
// A word with an out-of-range colour goes straight to its result. Any other
// word runs one front check always, one more per point dropped from the
// front, plus one extra check when the window store is full. Each check
// reads the front entry, then its colour count, then decides. Pops are
// amortised. The cost is set by the read-modify-write sequence on the
// per-colour count memory and the window store, each of which has a
// registered read.
// The output word sits in a register. A new input word is taken as soon as
// the sequencer is idle, even while the receiver stalls on the last
// result. A finished result waits in the last state until the output
// register is free.
// Reset clears the counts via per-entry valid bits and needs no clearing
// pass. The window store has no reset.
// ============================================================================
module min_span_covering_all_colors
    import mscac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COLOR_W-1:0] color,
    input  logic [POS_W-1:0]   position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [POS_W-1:0]   best_span,
    output logic               all_covered,
    output logic               window_overflow,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data
);

    seq_state_t state_reg, state_next;

    logic [CFG_W-1:0]  colors_reg;
    logic [CFG_W-1:0]  k_eff;
    logic              foreign;

    logic [COLOR_W-1:0] item_color_reg;
    logic [POS_W-1:0]   item_pos_reg;
    logic               evict_reg, evict_next;

    logic [WIN_AW-1:0]  front_reg, front_next;
    logic [WIN_AW-1:0]  back_reg, back_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [DIST_W-1:0]  distinct_reg, distinct_next;
    logic [POS_W-1:0]   best_reg, best_next;
    logic               overflow_reg, overflow_next;

    logic [COLOR_W-1:0] front_col_reg;
    logic [POS_W-1:0]   front_pos_reg;

    // window store
    win_entry_t         win_mem [WIN_DEPTH];
    win_entry_t         win_q_reg;
    logic               win_we;
    logic               win_re;

    // per-colour counts
    logic [CNT_W-1:0]     cnt_mem [MAX_COLORS];
    logic [MAX_COLORS-1:0] cnt_vld_reg;
    logic [CNT_W-1:0]     cnt_q_reg;
    logic                 cnt_qv_reg;
    logic [CNT_W-1:0]     cnt_val;
    logic                 cnt_we;
    logic [COL_IDX_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]     cnt_wdata;
    logic                 cnt_re;
    logic [COL_IDX_W-1:0] cnt_raddr;

    logic               covered_now;
    logic [POS_W-1:0]   span;

    logic               out_valid_reg;
    logic [POS_W-1:0]   out_best_reg;
    logic               out_cov_reg;
    logic               out_ovf_reg;
    logic               out_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        if (colors_reg == '0)
            k_eff = CFG_W'(1);
        else if (colors_reg > K_MAX)
            k_eff = K_MAX;
        else
            k_eff = colors_reg;
    end

    // k_eff never exceeds MAX_COLORS, so this also rejects colours beyond the table
    assign foreign     = ({1'b0, color} >= k_eff);
    assign covered_now = (fill_reg != '0) && (CMP_W'(distinct_reg) >= CMP_W'(k_eff));
    assign cnt_val     = cnt_qv_reg ? cnt_q_reg : '0;
    assign span        = (item_pos_reg >= front_pos_reg) ? (item_pos_reg - front_pos_reg) : '0;
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        evict_next    = evict_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        fill_next     = fill_reg;
        distinct_next = distinct_reg;
        best_next     = best_reg;
        overflow_next = overflow_reg;
        win_we        = 1'b0;
        win_re        = 1'b0;
        cnt_we        = 1'b0;
        cnt_waddr     = COL_IDX_W'(front_col_reg);
        cnt_wdata     = cnt_val;
        cnt_re        = 1'b0;
        cnt_raddr     = COL_IDX_W'(item_color_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (foreign)
                        state_next = ST_DONE;
                    else if (fill_reg == FILL_FULL)
                    begin
                        evict_next = 1'b1;
                        state_next = ST_FRONT_RD;
                    end
                    else
                        state_next = ST_PUSH;
                end
            end
            ST_FRONT_RD:
            begin
                win_re     = 1'b1;
                state_next = ST_FRONT_CNT;
            end
            ST_FRONT_CNT:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = COL_IDX_W'(win_q_reg.color);
                state_next = ST_FRONT_CHK;
            end
            ST_FRONT_CHK:
            begin
                if (evict_reg || (cnt_val > CNT_W'(1)))
                begin
                    if (cnt_val != '0)
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_val - CNT_W'(1);
                        if ((cnt_val == CNT_W'(1)) && (distinct_reg != '0))
                            distinct_next = distinct_reg - DIST_W'(1);
                    end
                    front_next = (front_reg == PTR_LAST) ? '0 : front_reg + WIN_AW'(1);
                    fill_next  = fill_reg - FILL_W'(1);
                    if (evict_reg)
                    begin
                        overflow_next = 1'b1;
                        evict_next    = 1'b0;
                        state_next    = ST_PUSH;
                    end
                    else
                        state_next = ST_FRONT_RD;
                end
                else
                begin
                    if ((CMP_W'(distinct_reg) >= CMP_W'(k_eff)) && (span < best_reg))
                        best_next = span;
                    state_next = ST_DONE;
                end
            end
            ST_PUSH:
            begin
                win_we     = 1'b1;
                cnt_re     = 1'b1;
                back_next  = (back_reg == PTR_LAST) ? '0 : back_reg + WIN_AW'(1);
                fill_next  = fill_reg + FILL_W'(1);
                state_next = ST_PUSH_CNT;
            end
            ST_PUSH_CNT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = COL_IDX_W'(item_color_reg);
                cnt_wdata = cnt_val + CNT_W'(1);
                if (cnt_val == '0)
                    distinct_next = distinct_reg + DIST_W'(1);
                state_next = ST_FRONT_RD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            evict_reg     <= 1'b0;
            front_reg     <= '0;
            back_reg      <= '0;
            fill_reg      <= '0;
            distinct_reg  <= '0;
            best_reg      <= NO_SPAN;
            overflow_reg  <= 1'b0;
            colors_reg    <= CFG_RESET;
            cnt_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            evict_reg    <= evict_next;
            front_reg    <= front_next;
            back_reg     <= back_next;
            fill_reg     <= fill_next;
            distinct_reg <= distinct_next;
            best_reg     <= best_next;
            overflow_reg <= overflow_next;
            if (cfg_valid)
                colors_reg <= cfg_data;
            if (cnt_we)
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_color_reg <= color;
            item_pos_reg   <= position;
        end
        if (state_reg == ST_FRONT_CNT)
        begin
            front_col_reg <= win_q_reg.color;
            front_pos_reg <= win_q_reg.position;
        end
        if (out_load)
        begin
            out_best_reg <= best_reg;
            out_cov_reg  <= covered_now;
            out_ovf_reg  <= overflow_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
            win_mem[back_reg] <= '{color: item_color_reg, position: item_pos_reg};
        if (win_re)
            win_q_reg <= win_mem[front_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
        begin
            cnt_q_reg  <= cnt_mem[cnt_raddr];
            cnt_qv_reg <= cnt_vld_reg[cnt_raddr];
        end
    end

    assign out_valid       = out_valid_reg;
    assign best_span       = out_best_reg;
    assign all_covered     = out_cov_reg;
    assign window_overflow = out_ovf_reg;

endmodule
